// File: hw/rtl/sblt_pkg.sv
// Shared types and constants of the segment base/limit translator.
package sblt_pkg;

  localparam int SEGMENTS  = 16;
  localparam int ADDR_BITS = 31;
  localparam int IDX_W     = $clog2(SEGMENTS);
  localparam int COUNT_W   = $clog2(SEGMENTS + 1);
  localparam int ENTRY_W   = 2 * ADDR_BITS;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = ADDR_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_SPACE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT  = 1'd1;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_FORWARD = 2'd1;
  localparam logic [1:0] KIND_REVERSE = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SEG    = 3'd1;
  localparam logic [2:0] ST_UNMAPPED   = 3'd2;
  localparam logic [2:0] ST_OFFSET_OUT = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_PHYS_OUT   = 3'd5;
  localparam logic [2:0] ST_WR_REJECT  = 3'd6;

  typedef struct packed {
    logic [1:0]           kind;
    logic [IDX_W-1:0]     seg_index;
    logic [ADDR_BITS-1:0] seg_offset;
    logic [ADDR_BITS-1:0] phys_in;
    logic [ADDR_BITS-1:0] new_base;
    logic [ADDR_BITS-1:0] new_limit;
    logic                 new_mapped;
  } item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] phys_out;
    logic [IDX_W-1:0]     seg_out;
    logic [ADDR_BITS-1:0] offset_out;
    logic [ADDR_BITS-1:0] hit_base;
    logic [ADDR_BITS-1:0] hit_limit;
  } result_t;

  typedef enum logic [2:0] {
    SRC_WRITE,
    SRC_FWD_EARLY,
    SRC_FWD,
    SRC_PHYS_OUT,
    SRC_REV_HIT,
    SRC_REV_MISS
  } res_src_t;

  typedef struct packed {
    logic     capture;
    logic     wr_commit;
    logic     scan_init;
    logic     scan_en;
    logic     load;
    res_src_t src;
  } dp_cmd_t;

  typedef struct packed {
    logic fwd_early;
    logic space_bad;
    logic hit;
    logic exhausted;
  } dp_stat_t;

endpackage

// File: hw/rtl/sblt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sblt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/sblt_ctrl.sv
// Sequencing state machine of the segment base/limit translator.
module sblt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         kind,
  input  sblt_pkg::dp_stat_t stat,
  output sblt_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import sblt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_WRITE   = 6'b000010,
    S_FWD     = 6'b000100,
    S_FWD_CHK = 6'b001000,
    S_REV     = 6'b010000,
    S_SCAN    = 6'b100000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.src       = SRC_WRITE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          unique case (kind)
            KIND_WRITE:   state_next = S_WRITE;
            KIND_FORWARD: state_next = S_FWD;
            KIND_REVERSE: state_next = S_REV;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.wr_commit = 1'b1;
        cmd.load      = 1'b1;
        cmd.src       = SRC_WRITE;
        state_next    = S_IDLE;
      end
      S_FWD: begin
        if (stat.fwd_early) begin
          cmd.load   = 1'b1;
          cmd.src    = SRC_FWD_EARLY;
          state_next = S_IDLE;
        end else begin
          state_next = S_FWD_CHK;
        end
      end
      S_FWD_CHK: begin
        cmd.load   = 1'b1;
        cmd.src    = SRC_FWD;
        state_next = S_IDLE;
      end
      S_REV: begin
        if (stat.space_bad) begin
          cmd.load   = 1'b1;
          cmd.src    = SRC_PHYS_OUT;
          state_next = S_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        priority if (stat.hit) begin
          cmd.load   = 1'b1;
          cmd.src    = SRC_REV_HIT;
          state_next = S_IDLE;
        end else if (stat.exhausted) begin
          cmd.load   = 1'b1;
          cmd.src    = SRC_REV_MISS;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/sblt_dp.sv
// Datapath: config registers, segment table, comparators and result word.
module sblt_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sblt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sblt_pkg::CFG_W-1:0]        cfg_data,
  input  sblt_pkg::item_t                   item,
  input  sblt_pkg::dp_cmd_t                 cmd,
  output sblt_pkg::dp_stat_t                stat,
  output logic                              done,
  output sblt_pkg::result_t                 result
);
  import sblt_pkg::*;

  logic [ADDR_BITS-1:0] phys_space;
  logic [4:0]           seg_count_cfg;
  logic [COUNT_W-1:0]   count;
  item_t                cur;
  logic [SEGMENTS-1:0]  valid;
  logic [COUNT_W-1:0]   ptr;
  logic                 pend;
  logic [IDX_W-1:0]     pidx;
  logic [IDX_W-1:0]     raddr;
  logic [ENTRY_W-1:0]   rdata;
  logic [ADDR_BITS-1:0] e_base, e_limit;
  logic                 wr_reject, ram_we, issue;
  logic [ADDR_BITS:0]   wr_end, e_end;
  logic                 idx_out;
  result_t              res_next;

  // saturate the count at the table size
  assign count = (seg_count_cfg > 5'(SEGMENTS)) ? COUNT_W'(SEGMENTS)
                                                : COUNT_W'(seg_count_cfg);

  always_ff @(posedge clk) begin
    if (rst) begin
      phys_space    <= '0;
      seg_count_cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHYS_SPACE: phys_space    <= cfg_data;
        CFG_SEG_COUNT:  seg_count_cfg <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item;
    end
  end

  assign idx_out   = ({1'b0, cur.seg_index} >= (IDX_W+1)'(count));
  assign wr_end    = {1'b0, cur.new_base} + {1'b0, cur.new_limit};
  assign wr_reject = idx_out || (cur.new_mapped && (wr_end > {1'b0, phys_space}));
  assign ram_we    = cmd.wr_commit && !wr_reject;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[cur.seg_index] <= cur.new_mapped;
    end
  end

  // scan pointer: issue one table read a cycle, check it the next
  assign issue = (ptr < count);
  assign raddr = cmd.scan_en ? ptr[IDX_W-1:0] : cur.seg_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      ptr  <= '0;
    end else if (cmd.scan_init) begin
      pend <= 1'b0;
      ptr  <= '0;
    end else if (cmd.scan_en) begin
      pend <= issue;
      ptr  <= ptr + COUNT_W'(issue);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      pidx <= ptr[IDX_W-1:0];
    end
  end

  sblt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur.seg_index),
    .wdata ({cur.new_base, cur.new_limit}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign e_base  = rdata[ENTRY_W-1:ADDR_BITS];
  assign e_limit = rdata[ADDR_BITS-1:0];
  assign e_end   = {1'b0, e_base} + {1'b0, e_limit};

  assign stat.fwd_early = idx_out || !valid[cur.seg_index];
  assign stat.space_bad = (cur.phys_in >= phys_space);
  assign stat.hit       = pend && valid[pidx] && (cur.phys_in >= e_base)
                          && ({1'b0, cur.phys_in} < e_end);
  assign stat.exhausted = !issue && !stat.hit;

  always_comb begin
    res_next = '0;
    unique case (cmd.src)
      SRC_WRITE: begin
        res_next.status = wr_reject ? ST_WR_REJECT : ST_OK;
      end
      SRC_FWD_EARLY: begin
        res_next.status = idx_out ? ST_BAD_SEG : ST_UNMAPPED;
      end
      SRC_FWD: begin
        res_next.hit_base  = e_base;
        res_next.hit_limit = e_limit;
        if (cur.seg_offset >= e_limit) begin
          res_next.status = ST_OFFSET_OUT;
        end else begin
          res_next.status   = ST_OK;
          res_next.phys_out = e_base + cur.seg_offset;
        end
      end
      SRC_PHYS_OUT: begin
        res_next.status = ST_PHYS_OUT;
      end
      SRC_REV_HIT: begin
        res_next.status     = ST_OK;
        res_next.seg_out    = pidx;
        res_next.offset_out = cur.phys_in - e_base;
        res_next.hit_base   = e_base;
        res_next.hit_limit  = e_limit;
      end
      SRC_REV_MISS: begin
        res_next.status = ST_NOT_FOUND;
      end
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result <= res_next;
    end
  end

endmodule

// File: hw/rtl/segment_base_limit_translator_unit.sv
// Top level of the segment base/limit address translator.
//
// Users: an item is taken at a clock edge where start is high and busy is
// low; every item of kind write, forward or reverse yields exactly one
// result word, flagged by done, which is high for a single cycle. The
// receiver cannot stall, so sample result whenever done is set. The word
// stays on result until the next is loaded. An item of kind three is
// dropped with no result. A write commits unless rejected; forward reads
// the entry and ends there on a bad or unmapped segment, else checks the
// offset against the limit in a second state; reverse ends when the
// address lies outside physical space, otherwise scans entries up to the
// segment count until a hit or a miss, one table read a cycle through
// the single read port of the entry RAM, one base/limit comparator.
// Busy drops in the cycle done is high, so the next item may be taken then.
// No item overlaps another. Mapped flags clear at reset, no clearing pass;
// base and limit of an entry never written are never used. Write the config
// registers (index 0 physical space size, index 1 segment count, saturated
// at SEGMENTS) only while busy is low and no result is pending.
module segment_base_limit_translator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  sblt_pkg::item_t                item,
  output logic                           done,
  output sblt_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [sblt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sblt_pkg::CFG_W-1:0]     cfg_data
);
  import sblt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence each item: capture, write, read or scan the table, load the result
  sblt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // hold config, the table and the result word
  sblt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule
